/* rtl/gai_pkg.sv */
`timescale 1ns / 1ps

package gai_pkg;

    localparam int NAXES      = 3;
    localparam int AXIS_W     = 2;
    localparam int RAW_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int BIAS_W     = 24;
    localparam int RATE_W     = 22;
    localparam int ANG_W      = 48;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 8;
    localparam int SCALE_W    = 16;
    localparam int HSTEP_W    = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int PIPE_DEPTH = 4;

    localparam int CAL_SAMPLES_DEF = 100;
    localparam int CAL_SAMPLES_MAX = 2 ** CNT_W - 1;

    localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 16'd4583;
    localparam logic [HSTEP_W-1:0] HALF_STEP_RST  = 24'd16777;
    localparam logic [BIAS_W-1:0]  BIAS_RST       = 24'd26;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP  = 1'b1;

    typedef logic [AXIS_W-1:0] t_axis;

    typedef struct packed {
        logic  capture;
        logic  s1_en;
        t_axis s1_axis;
        logic  s2_en;
        t_axis s2_axis;
        logic  s3_en;
        t_axis s3_axis;
        logic  s4_en;
        t_axis s4_axis;
        logic  div_start;
        logic  bias_wr;
        t_axis div_axis;
        logic  load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_cal;
        logic cal_last;
        logic div_done;
    } t_dp_stat;

endpackage

/* rtl/gai_div.sv */
`timescale 1ns / 1ps

module gai_div #(
    parameter int DVD_W   = 32,
    parameter int DVS_W   = 8,
    parameter int DIVISOR = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);

    // split the dividend into a high part and one low digit, divide each by the
    // constant with a reciprocal multiply and carry the remainder down
    localparam int HI_W = DVD_W - DVS_W;
    localparam int Y_W  = 2 * DVS_W;
    localparam int SHL  = $clog2(DIVISOR);
    localparam int P1_W = 2 * HI_W + DVS_W + 1;
    localparam int P2_W = 2 * Y_W + DVS_W + 1;

    localparam longint M1_L = ((longint'(1) << (HI_W + SHL)) + DIVISOR - 1) / DIVISOR;
    localparam longint M2_L = ((longint'(1) << (Y_W + SHL)) + DIVISOR - 1) / DIVISOR;

    localparam logic [P1_W-1:0] M1     = P1_W'(M1_L);
    localparam logic [P2_W-1:0] M2     = P2_W'(M2_L);
    localparam logic [HI_W-1:0] DVS_HI = HI_W'(DIVISOR);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HI,
        PH_REM,
        PH_LO
    } t_phase;

    t_phase           r_phase;
    logic [HI_W-1:0]  r_xh;
    logic [DVS_W-1:0] r_xl;
    logic [HI_W-1:0]  r_q1;
    logic [Y_W-1:0]   r_y;
    logic [DVD_W-1:0] r_quo;
    logic             r_done;

    logic [P1_W-1:0]  p1;
    logic [HI_W-1:0]  q1;
    logic [HI_W-1:0]  qd;
    logic [HI_W-1:0]  rem1;
    logic [Y_W-1:0]   n_y;
    logic [P2_W-1:0]  p2;
    logic [DVS_W-1:0] q2;

    always_comb begin
        p1   = P1_W'(r_xh) * M1;
        q1   = p1[HI_W+SHL +: HI_W];
        qd   = r_q1 * DVS_HI;
        rem1 = r_xh - qd;
        n_y  = {rem1[DVS_W-1:0], r_xl};
        p2   = P2_W'(r_y) * M2;
        q2   = p2[Y_W+SHL +: DVS_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == PH_LO);
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_xh    <= i_dividend[DVD_W-1:DVS_W];
                        r_xl    <= i_dividend[DVS_W-1:0];
                        r_phase <= PH_HI;
                    end
                end
                PH_HI: begin
                    r_q1    <= q1;
                    r_phase <= PH_REM;
                end
                PH_REM: begin
                    r_y     <= n_y;
                    r_phase <= PH_LO;
                end
                PH_LO: begin
                    r_quo   <= {r_q1, q2};
                    r_phase <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

/* rtl/gai_dp.sv */
`timescale 1ns / 1ps

module gai_dp #(
    parameter int NCAL = 100
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gai_pkg::t_dp_cmd                     i_ctl,
    output gai_pkg::t_dp_stat                    o_stat,
    input  logic                                 i_cfg_wr_en,
    input  logic [gai_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gai_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                 i_cmd,
    input  logic signed [gai_pkg::RAW_W-1:0]     i_raw   [gai_pkg::NAXES],
    output logic signed [gai_pkg::RATE_W-1:0]    o_rate  [gai_pkg::NAXES],
    output logic signed [gai_pkg::ANG_W-1:0]     o_angle [gai_pkg::NAXES],
    output logic                                 o_cal_done
);
    import gai_pkg::*;

    localparam int P1_W  = BIAS_W + 1 + SCALE_W + 1;
    localparam int SH_W  = P1_W - SCALE_W;
    localparam int P2_W  = RATE_W + 1 + HSTEP_W + 1;
    localparam int INC_W = P2_W - HSTEP_W;
    localparam int DVD_W = SUM_W + FRAC_W;

    localparam logic [P1_W-1:0]  P1_HALF  = P1_W'(2 ** (SCALE_W - 1));
    localparam logic [P2_W-1:0]  P2_HALF  = P2_W'(2 ** (HSTEP_W - 1));
    localparam logic [CNT_W-1:0] NCAL_C   = CNT_W'(NCAL);
    localparam logic [DVD_W-1:0] NCAL_RND = DVD_W'(NCAL / 2);
    localparam logic [DVD_W-1:0] BIAS_POS_LIM = DVD_W'(2 ** (BIAS_W - 1) - 1);
    localparam logic [DVD_W-1:0] BIAS_NEG_LIM = DVD_W'(2 ** (BIAS_W - 1));

    localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W - 1){1'b1}}};
    localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W - 1){1'b0}}};
    localparam logic [ANG_W-1:0]  ANG_MAX  = {1'b0, {(ANG_W - 1){1'b1}}};
    localparam logic [ANG_W-1:0]  ANG_MIN  = {1'b1, {(ANG_W - 1){1'b0}}};
    localparam logic [BIAS_W-1:0] BIAS_MAX = {1'b0, {(BIAS_W - 1){1'b1}}};
    localparam logic [BIAS_W-1:0] BIAS_MIN = {1'b1, {(BIAS_W - 1){1'b0}}};

    // architectural state
    logic [SCALE_W-1:0] r_scale;
    logic [HSTEP_W-1:0] r_half;
    logic [BIAS_W-1:0]  r_bias  [NAXES];
    logic [RATE_W-1:0]  r_prev  [NAXES];
    logic [ANG_W-1:0]   r_angle [NAXES];
    logic [SUM_W-1:0]   r_sum   [NAXES];
    logic [CNT_W-1:0]   r_count;

    // item and pipeline payload
    logic [RAW_W-1:0]   r_raw   [NAXES];
    logic               r_cmd;
    logic               r_cal_last;
    logic [RATE_W-1:0]  r_rate  [NAXES];
    logic signed [P1_W-1:0] r_p1;
    logic signed [P2_W-1:0] r_p2;
    logic [RATE_W-1:0]  r_o_rate  [NAXES];
    logic [ANG_W-1:0]   r_o_angle [NAXES];
    logic               r_o_done;

    logic [CNT_W-1:0]   cnt_inc;
    logic               cnt_last;

    logic signed [BIAS_W:0]     s1_diff;
    logic signed [P1_W-1:0]     s1_prod;
    logic [P1_W-1:0]            s2_round;
    logic [SH_W-1:0]            s2_shift;
    logic [SH_W-RATE_W:0]       s2_top;
    logic [RATE_W-1:0]          s2_rate;
    logic signed [RATE_W:0]     s3_sum;
    logic signed [P2_W-1:0]     s3_prod;
    logic [P2_W-1:0]            s4_round;
    logic [INC_W-1:0]           s4_inc;
    logic [ANG_W:0]             s4_sum;
    logic [ANG_W-1:0]           s4_angle;

    logic [SUM_W-1:0]   div_sum;
    logic               div_neg;
    logic [SUM_W-1:0]   div_mag;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVD_W-1:0]   div_quo;
    logic               div_done;
    logic [BIAS_W-1:0]  new_bias;

    always_comb begin
        cnt_inc  = r_count + 1'b1;
        cnt_last = (cnt_inc >= NCAL_C);
    end

    // stage 1: remove bias, scale
    always_comb begin
        s1_diff = $signed({r_raw[i_ctl.s1_axis][RAW_W-1], r_raw[i_ctl.s1_axis], {FRAC_W{1'b0}}})
                - $signed({r_bias[i_ctl.s1_axis][BIAS_W-1], r_bias[i_ctl.s1_axis]});
        s1_prod = s1_diff * $signed({1'b0, r_scale});
    end

    // stage 2: round to Q.8 and saturate
    always_comb begin
        s2_round = r_p1 + P1_HALF;
        s2_shift = s2_round[P1_W-1:SCALE_W];
        s2_top   = s2_shift[SH_W-1:RATE_W-1];
        if ((&s2_top) || !(|s2_top)) begin
            s2_rate = s2_shift[RATE_W-1:0];
        end else begin
            s2_rate = s2_top[SH_W-RATE_W] ? RATE_MIN : RATE_MAX;
        end
    end

    // stage 3: trapezoid sum times half step
    always_comb begin
        s3_sum  = $signed({r_rate[i_ctl.s3_axis][RATE_W-1], r_rate[i_ctl.s3_axis]})
                + $signed({r_prev[i_ctl.s3_axis][RATE_W-1], r_prev[i_ctl.s3_axis]});
        s3_prod = s3_sum * $signed({1'b0, r_half});
    end

    // stage 4: round to Q.8 and accumulate with saturation
    always_comb begin
        s4_round = r_p2 + P2_HALF;
        s4_inc   = s4_round[P2_W-1:HSTEP_W];
        s4_sum   = {r_angle[i_ctl.s4_axis][ANG_W-1], r_angle[i_ctl.s4_axis]}
                 + {{(ANG_W + 1 - INC_W){s4_inc[INC_W-1]}}, s4_inc};
        if (s4_sum[ANG_W] != s4_sum[ANG_W-1]) begin
            s4_angle = s4_sum[ANG_W] ? ANG_MIN : ANG_MAX;
        end else begin
            s4_angle = s4_sum[ANG_W-1:0];
        end
    end

    // calibration mean: magnitude, rounding offset, then divide; restore sign, saturate
    always_comb begin
        div_sum = r_sum[i_ctl.div_axis];
        div_neg = div_sum[SUM_W-1];
        div_mag = div_neg ? (~div_sum + 1'b1) : div_sum;
        div_dvd = {div_mag, {FRAC_W{1'b0}}} + NCAL_RND;
        if (div_neg) begin
            new_bias = (div_quo > BIAS_NEG_LIM) ? BIAS_MIN : (~div_quo[BIAS_W-1:0] + 1'b1);
        end else begin
            new_bias = (div_quo > BIAS_POS_LIM) ? BIAS_MAX : div_quo[BIAS_W-1:0];
        end
    end

    gai_div #(
        .DVD_W   (DVD_W),
        .DVS_W   (CNT_W),
        .DIVISOR (NCAL)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (div_dvd),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= RATE_SCALE_RST;
            r_half  <= HALF_STEP_RST;
            r_count <= '0;
            for (int i = 0; i < NAXES; i++) begin
                r_bias[i]  <= BIAS_RST;
                r_prev[i]  <= '0;
                r_angle[i] <= '0;
                r_sum[i]   <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_RATE_SCALE: r_scale <= i_cfg_wdata[SCALE_W-1:0];
                    REG_HALF_STEP:  r_half  <= i_cfg_wdata[HSTEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.capture && i_cmd) begin
                r_count <= cnt_last ? '0 : cnt_inc;
                for (int i = 0; i < NAXES; i++) begin
                    r_sum[i] <= r_sum[i] + {{(SUM_W - RAW_W){i_raw[i][RAW_W-1]}}, i_raw[i]};
                end
            end
            if (i_ctl.s3_en) begin
                r_prev[i_ctl.s3_axis] <= r_rate[i_ctl.s3_axis];
            end
            if (i_ctl.s4_en) begin
                r_angle[i_ctl.s4_axis] <= s4_angle;
            end
            if (i_ctl.bias_wr) begin
                r_bias[i_ctl.div_axis]  <= new_bias;
                r_angle[i_ctl.div_axis] <= '0;
                r_sum[i_ctl.div_axis]   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd      <= i_cmd;
            r_cal_last <= i_cmd && cnt_last;
            for (int i = 0; i < NAXES; i++) begin
                r_raw[i] <= i_raw[i];
            end
        end
        if (i_ctl.s1_en) begin
            r_p1 <= s1_prod;
        end
        if (i_ctl.s2_en) begin
            r_rate[i_ctl.s2_axis] <= s2_rate;
        end
        if (i_ctl.s3_en) begin
            r_p2 <= s3_prod;
        end
        if (i_ctl.load_out) begin
            r_o_done <= r_cal_last;
            for (int i = 0; i < NAXES; i++) begin
                r_o_rate[i]  <= r_cmd ? '0 : r_rate[i];
                r_o_angle[i] <= r_angle[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NAXES; i++) begin
            o_rate[i]  = r_o_rate[i];
            o_angle[i] = r_o_angle[i];
        end
    end

    assign o_cal_done      = r_o_done;
    assign o_stat.cmd_cal  = r_cmd;
    assign o_stat.cal_last = r_cal_last;
    assign o_stat.div_done = div_done;

endmodule

/* rtl/gai_ctrl.sv */
`timescale 1ns / 1ps

module gai_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  gai_pkg::t_dp_stat  i_stat,
    output gai_pkg::t_dp_cmd   o_ctl
);
    import gai_pkg::*;

    localparam int STEP_N = NAXES + PIPE_DEPTH - 1;
    localparam int STEP_W = $clog2(STEP_N);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEP_N - 1);
    localparam logic [STEP_W-1:0] S1_END    = STEP_W'(NAXES);
    localparam logic [STEP_W-1:0] S2_END    = STEP_W'(NAXES + 1);
    localparam logic [STEP_W-1:0] S3_END    = STEP_W'(NAXES + 2);
    localparam logic [STEP_W-1:0] STEP_ONE  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_TWO  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_THR  = STEP_W'(3);
    localparam t_axis LAST_AXIS = AXIS_W'(NAXES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_MEAS,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    t_axis             r_axis;
    logic              r_o_valid;

    logic meas;
    logic out_free;

    always_comb begin
        meas     = (r_state == ST_MEAS);
        out_free = !r_o_valid || !i_stall;

        o_ctl           = '0;
        o_ctl.capture   = (r_state == ST_IDLE) && i_valid;
        // axis k enters stage n at step k + n - 1
        o_ctl.s1_en     = meas && (r_step < S1_END);
        o_ctl.s1_axis   = t_axis'(r_step);
        o_ctl.s2_en     = meas && (r_step >= STEP_ONE) && (r_step < S2_END);
        o_ctl.s2_axis   = t_axis'(r_step - STEP_ONE);
        o_ctl.s3_en     = meas && (r_step >= STEP_TWO) && (r_step < S3_END);
        o_ctl.s3_axis   = t_axis'(r_step - STEP_TWO);
        o_ctl.s4_en     = meas && (r_step >= STEP_THR);
        o_ctl.s4_axis   = t_axis'(r_step - STEP_THR);
        o_ctl.div_start = (r_state == ST_DIV_GO);
        o_ctl.div_axis  = r_axis;
        o_ctl.bias_wr   = (r_state == ST_DIV_WAIT) && i_stat.div_done;
        o_ctl.load_out  = (r_state == ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_axis    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ctl.load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_step <= '0;
                    r_axis <= '0;
                    if (!i_stat.cmd_cal) begin
                        r_state <= ST_MEAS;
                    end else if (i_stat.cal_last) begin
                        r_state <= ST_DIV_GO;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_MEAS: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV_GO: begin
                    r_state <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (i_stat.div_done) begin
                        if (r_axis == LAST_AXIS) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= ST_DIV_GO;
                        end
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_o_valid;

endmodule

/* rtl/gyro_angle_integrator.sv */
`timescale 1ns / 1ps
// The three axes share one four-stage scale/integrate pipeline, one axis entering per cycle
// in measure; the block takes no new item until it is through with the last one.
// The sample that closes a calibration run adds a reciprocal divide, one axis at a time.
// A result held by a stalled output keeps the next item waiting.
// Reset (synchronous, active low) restores default scale, half step and bias, clears angles.

module gyro_angle_integrator #(
    parameter int CAL_SAMPLES = gai_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic signed [gai_pkg::RAW_W-1:0]    i_raw_x,
    input  logic signed [gai_pkg::RAW_W-1:0]    i_raw_y,
    input  logic signed [gai_pkg::RAW_W-1:0]    i_raw_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [gai_pkg::RATE_W-1:0]   o_rate_x,
    output logic signed [gai_pkg::RATE_W-1:0]   o_rate_y,
    output logic signed [gai_pkg::RATE_W-1:0]   o_rate_z,
    output logic signed [gai_pkg::ANG_W-1:0]    o_angle_out_x,
    output logic signed [gai_pkg::ANG_W-1:0]    o_angle_out_y,
    output logic signed [gai_pkg::ANG_W-1:0]    o_angle_out_z,
    output logic                                o_cal_done,
    input  logic                                i_cfg_wr_en,
    input  logic [gai_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gai_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import gai_pkg::*;

    localparam int NCAL = (CAL_SAMPLES < 1) ? 1 :
                          ((CAL_SAMPLES > CAL_SAMPLES_MAX) ? CAL_SAMPLES_MAX : CAL_SAMPLES);

    t_dp_cmd   ctl;
    t_dp_stat  stat;

    logic signed [RAW_W-1:0]  raw   [NAXES];
    logic signed [RATE_W-1:0] rate  [NAXES];
    logic signed [ANG_W-1:0]  angle [NAXES];

    assign raw[0] = i_raw_x;
    assign raw[1] = i_raw_y;
    assign raw[2] = i_raw_z;

    gai_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    gai_dp #(
        .NCAL (NCAL)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_raw       (raw),
        .o_rate      (rate),
        .o_angle     (angle),
        .o_cal_done  (o_cal_done)
    );

    assign o_rate_x      = rate[0];
    assign o_rate_y      = rate[1];
    assign o_rate_z      = rate[2];
    assign o_angle_out_x = angle[0];
    assign o_angle_out_y = angle[1];
    assign o_angle_out_z = angle[2];

endmodule
